// ===== design/u16u8_pkg.sv =====
// Shared types, constants and the UTF-8 encoder function of the UTF-16LE to UTF-8 transcoder.
package u16u8_pkg;

	localparam int unsigned JobBytes = 6;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW = $clog2(QueueDepth);

	localparam logic [15:0] HighFirst = 16'hD800;
	localparam logic [15:0] HighLast = 16'hDBFF;
	localparam logic [15:0] LowFirst = 16'hDC00;
	localparam logic [15:0] LowLast = 16'hDFFF;
	localparam logic [20:0] PlaneBase = 21'h10000;
	localparam logic [20:0] Limit1 = 21'h80;
	localparam logic [20:0] Limit2 = 21'h800;
	localparam logic [20:0] Limit3 = 21'h10000;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} enc_t;

	typedef struct packed {
		logic [JobBytes-1:0][7:0] bytes;
		logic [2:0]               count;
		logic                     fin;
	} job_t;

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e.b = '0;
		if (cp < Limit1) begin
			e.b[0] = cp[7:0];
			e.len = 3'd1;
		end else if (cp < Limit2) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.len = 3'd2;
		end else if (cp < Limit3) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.len = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.len = 3'd4;
		end
		return e;
	endfunction

endpackage

// ===== design/utf16le_to_utf8_transcoder_core.sv =====
// Top level of the UTF-16LE to UTF-8 transcoder: front end, transaction queue and serializer.
//
//   Channel  Handshake               Payload
//   unit     unit_valid/unit_stall   code_unit[15:0], final_unit
//   byte     byte_valid/byte_stall   utf8_byte[7:0], run_last, string_end
//
// A code unit is taken whenever the queue has room, and the serializer gives one byte per
// cycle while byte_stall is low; a unit yields zero to six bytes.
// The queue holds four transactions; unit_stall rises only when it is full.
// Reset clears the held surrogate, the queue pointers and the output valid flag.
// A stalled output keeps its byte while the front end keeps taking units until the queue fills.
module utf16le_to_utf8_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  utf8_byte,
	output logic        run_last,
	output logic        string_end
);

	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_not_empty;
	u16u8_pkg::job_t push_job;
	u16u8_pkg::job_t head_job;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.queue_full (queue_full),
		.unit_stall (unit_stall),
		.push       (push),
		.push_job   (push_job)
	);

	u16u8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head_job  (head_job)
	);

	u16u8_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.queue_not_empty (queue_not_empty),
		.head_job        (head_job),
		.pop             (pop),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.utf8_byte       (utf8_byte),
		.run_last        (run_last),
		.string_end      (string_end)
	);

endmodule

// ===== design/u16u8_front.sv =====
// Front end: accepts code units, pairs surrogates and builds the byte list of each transaction.
module u16u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 unit_valid,
	input  logic [15:0]          code_unit,
	input  logic                 final_unit,
	input  logic                 queue_full,
	output logic                 unit_stall,
	output logic                 push,
	output u16u8_pkg::job_t      push_job
);

	logic       high_pending_q;
	logic [9:0] held_high_bits_q;
	logic       is_high;
	logic       is_low;
	logic       pair;
	logic       lone_held;
	logic       hold_now;
	logic       accept;
	logic [20:0] cp_b;
	u16u8_pkg::enc_t held_enc;
	u16u8_pkg::enc_t cur_enc;

	assign is_high = (code_unit >= u16u8_pkg::HighFirst) && (code_unit <= u16u8_pkg::HighLast);
	assign is_low = (code_unit >= u16u8_pkg::LowFirst) && (code_unit <= u16u8_pkg::LowLast);
	assign pair = high_pending_q && is_low;
	assign lone_held = high_pending_q && !is_low;
	assign hold_now = !pair && is_high && !final_unit;

	assign unit_stall = queue_full;
	assign accept = unit_valid && !queue_full;

	assign cp_b = pair ? (u16u8_pkg::PlaneBase + {1'b0, held_high_bits_q, code_unit[9:0]})
		: {5'd0, code_unit};
	assign held_enc = u16u8_pkg::encode({5'd0, u16u8_pkg::HighFirst | {6'd0, held_high_bits_q}});
	assign cur_enc = u16u8_pkg::encode(cp_b);

	always_comb begin
		push_job.fin = final_unit;
		push_job.bytes = '0;
		if (lone_held) begin
			push_job.bytes[2:0] = held_enc.b[2:0];
			push_job.bytes[5:3] = cur_enc.b[2:0];
			push_job.count = hold_now ? 3'd3 : 3'd3 + cur_enc.len;
		end else begin
			push_job.bytes[3:0] = cur_enc.b;
			push_job.count = cur_enc.len;
		end
	end

	assign push = accept && (high_pending_q || !hold_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			held_high_bits_q <= '0;
		end else if (accept) begin
			high_pending_q <= hold_now;
			held_high_bits_q <= hold_now ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

// ===== design/u16u8_queue.sv =====
// Short queue of byte-list transactions between the front end and the serializer.
module u16u8_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16u8_pkg::job_t push_job,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output u16u8_pkg::job_t head_job
);

	u16u8_pkg::job_t entries_q [u16u8_pkg::QueueDepth];
	logic [u16u8_pkg::QueuePtrW-1:0] wr_ptr_q;
	logic [u16u8_pkg::QueuePtrW-1:0] rd_ptr_q;
	logic [u16u8_pkg::QueuePtrW:0]   count_q;

	assign full = count_q == (u16u8_pkg::QueuePtrW+1)'(u16u8_pkg::QueueDepth);
	assign not_empty = count_q != '0;
	assign head_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (u16u8_pkg::QueuePtrW)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (u16u8_pkg::QueuePtrW)'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (u16u8_pkg::QueuePtrW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (u16u8_pkg::QueuePtrW+1)'(1);
			end
		end
	end

endmodule

// ===== design/u16u8_back.sv =====
// Back end: serializes each queued transaction into UTF-8 bytes through an output register.
module u16u8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            queue_not_empty,
	input  u16u8_pkg::job_t head_job,
	output logic            pop,
	output logic            byte_valid,
	input  logic            byte_stall,
	output logic [7:0]      utf8_byte,
	output logic            run_last,
	output logic            string_end
);

	u16u8_pkg::job_t job_q;
	logic            busy_q;
	logic [2:0]      idx_q;
	logic            byte_valid_q;
	logic [7:0]      utf8_byte_q;
	logic            run_last_q;
	logic            string_end_q;
	logic            advance;
	logic            last_byte;

	assign advance = !byte_valid_q || !byte_stall;
	assign last_byte = idx_q == (job_q.count - 3'd1);
	assign pop = queue_not_empty && (!busy_q || (advance && last_byte));

	assign byte_valid = byte_valid_q;
	assign utf8_byte = utf8_byte_q;
	assign run_last = run_last_q;
	assign string_end = string_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			byte_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				byte_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (advance && busy_q) begin
				if (last_byte) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (advance && busy_q) begin
			utf8_byte_q <= job_q.bytes[idx_q];
			run_last_q <= last_byte;
			string_end_q <= last_byte && job_q.fin;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-16LE to UTF-8 transcoder core with its own byte predictor.
module tb;

	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles = 16;
	localparam int ReportLimit = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       string_end;
	} utf8_result_t;

	logic        clk;
	logic        arst_n;
	logic        unit_valid;
	logic        unit_stall;
	logic [15:0] code_unit;
	logic        final_unit;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  utf8_byte;
	logic        run_last;
	logic        string_end;

	utf8_result_t expected_bytes[$];
	logic [7:0]   unit_bytes[$];
	bit           surrogate_held;
	logic [9:0]   held_bits;
	bit           idle_en;
	int           failures;
	int           units_sent;
	int           quiet_cycles;

	utf16le_to_utf8_transcoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.utf8_byte  (utf8_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= ReportLimit) begin
			$display("%s", msg);
		end
	endtask

	task automatic add_byte(input logic [7:0] b);
		unit_bytes.insert(unit_bytes.size(), b);
	endtask

	task automatic append_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte(8'hC0 | {3'b0, cp[10:6]});
			add_byte(8'h80 | {2'b0, cp[5:0]});
		end else if (cp < 21'h10000) begin
			add_byte(8'hE0 | {4'b0, cp[15:12]});
			add_byte(8'h80 | {2'b0, cp[11:6]});
			add_byte(8'h80 | {2'b0, cp[5:0]});
		end else begin
			add_byte(8'hF0 | {5'b0, cp[20:18]});
			add_byte(8'h80 | {2'b0, cp[17:12]});
			add_byte(8'h80 | {2'b0, cp[11:6]});
			add_byte(8'h80 | {2'b0, cp[5:0]});
		end
	endtask

	task automatic encode_unit(input logic [15:0] u, input logic f);
		bit           is_high;
		bit           is_low;
		bit           paired;
		utf8_result_t r;
		is_high = (u >= u16u8_pkg::HighFirst) && (u <= u16u8_pkg::HighLast);
		is_low = (u >= u16u8_pkg::LowFirst) && (u <= u16u8_pkg::LowLast);
		paired = 1'b0;
		unit_bytes.delete();
		if (surrogate_held) begin
			surrogate_held = 1'b0;
			if (is_low) begin
				append_utf8(21'h10000 + {1'b0, held_bits, 10'b0} + {11'b0, u[9:0]});
				paired = 1'b1;
			end else begin
				append_utf8({5'b0, 6'b110110, held_bits});
			end
			held_bits = '0;
		end
		if (!paired) begin
			if (is_high && !f) begin
				surrogate_held = 1'b1;
				held_bits = u[9:0];
			end else begin
				append_utf8({5'b0, u});
			end
		end
		foreach (unit_bytes[k]) begin
			r.data = unit_bytes[k];
			r.run_last = (k == unit_bytes.size() - 1);
			r.string_end = r.run_last && f;
			expected_bytes.insert(expected_bytes.size(), r);
		end
	endtask

	task automatic send_unit(input logic [15:0] u, input logic f);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			unit_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		unit_valid = 1'b1;
		code_unit = u;
		final_unit = f;
		do @(posedge clk); while (unit_stall);
		encode_unit(u, f);
		units_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		unit_valid = 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_bmp();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hD7FF));
			default: return 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
	endfunction

	task automatic send_string(input int len);
		int  r;
		bit  last;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			last = (i == len - 1) && ($urandom_range(0, 9) != 0);
			if (r < 60) begin
				send_unit(pick_bmp(), last);
			end else if (r < 85) begin
				send_unit(16'($urandom_range(u16u8_pkg::HighFirst, u16u8_pkg::HighLast)), 1'b0);
				send_unit(16'($urandom_range(u16u8_pkg::LowFirst, u16u8_pkg::LowLast)), last);
			end else if (r < 92) begin
				send_unit(16'($urandom_range(u16u8_pkg::HighFirst, u16u8_pkg::HighLast)), last);
			end else if (r < 97) begin
				send_unit(16'($urandom_range(u16u8_pkg::LowFirst, u16u8_pkg::LowLast)), last);
			end else begin
				send_unit(16'($urandom), last);
			end
		end
	endtask

	task automatic send_strings(input int count);
		int target;
		target = units_sent + count;
		while (units_sent < target) send_string($urandom_range(1, 8));
	endtask

	task automatic test_directed();
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b1);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hD801, 1'b0);
		send_unit(16'hDBFE, 1'b0);
		send_unit(16'hDC37, 1'b0);
		send_unit(16'hDABC, 1'b1);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hD9AA, 1'b0);
		send_unit(16'hE000, 1'b1);
		send_unit(16'hDB00, 1'b0);
		send_unit(16'hD800, 1'b1);
		send_unit(16'hD7FF, 1'b1);
	endtask

	task automatic test_pause_until_drained();
		send_unit(16'hD8C3, 1'b0);
		send_unit(16'hDE01, 1'b0);
		send_unit(16'h20AC, 1'b1);
		wait_for_results();
		send_unit(16'h00E9, 1'b1);
	endtask

	task automatic test_random_strings();
		send_strings(230);
	endtask

	task automatic test_random_units();
		repeat (50) send_unit(16'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		send_strings(70);
	endtask

	initial begin
		byte_stall = 1'b0;
		forever begin
			int stall_left;
			@(negedge clk);
			if (stall_left > 0) begin
				byte_stall = 1'b1;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				byte_stall = 1'b1;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				byte_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		utf8_result_t want;
		if (arst_n && byte_valid && !byte_stall) begin
			if (expected_bytes.size() == 0) begin
				note_failure($sformatf("unexpected byte %02h run_last %0b string_end %0b",
					utf8_byte, run_last, string_end));
			end else begin
				want = expected_bytes.pop_front();
				if (utf8_byte !== want.data || run_last !== want.run_last
						|| string_end !== want.string_end) begin
					note_failure($sformatf({"byte mismatch: expected %02h/%0b/%0b",
						" actual %02h/%0b/%0b"}, want.data, want.run_last, want.string_end,
						utf8_byte, run_last, string_end));
				end
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((unit_valid && !unit_stall) || (byte_valid && !byte_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("** utf16le_to_utf8_transcoder_core: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		unit_valid = 1'b0;
		code_unit = '0;
		final_unit = 1'b0;
		surrogate_held = 1'b0;
		held_bits = '0;
		idle_en = 1'b1;
		failures = 0;
		units_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_pause_until_drained();
		test_random_strings();
		test_random_units();
		test_back_to_back();

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			note_failure($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
		end
		if (failures == 0) begin
			$display("** utf16le_to_utf8_transcoder_core: PASSED **");
		end else begin
			$display("** utf16le_to_utf8_transcoder_core: FAILED **");
		end
		$finish;
	end

endmodule

// ===== utf16le_to_utf8_transcoder_core.f =====
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16le_to_utf8_transcoder_core.sv
sim/tb.sv
